// ===== rtl/ipts_pkg.sv =====
// Shared constants, types and reset values for the parallel tempering step unit.
package ipts_pkg;

    localparam int LATTICE_SIDE  = 128;
    localparam int REPLICA_COUNT = 5;
    localparam int SITE_COUNT    = LATTICE_SIDE * LATTICE_SIDE;
    localparam int ROW_W         = $clog2(LATTICE_SIDE);
    localparam int IDX_W         = $clog2(REPLICA_COUNT);
    localparam int MEM_DEPTH     = REPLICA_COUNT * SITE_COUNT;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);

    localparam int SLOT_W        = 3;
    localparam int SITE_W        = 14;
    localparam int UNI_W         = 32;
    localparam int REP_OUT_W     = 3;
    localparam int E_OUT_W       = 17;
    localparam int BETA_W        = 20;
    localparam int BETA_REGS     = 5;
    localparam int BIDX_W        = 3;

    // Energy magnitude never exceeds twice the site count.
    localparam int E_W           = $clog2(2 * SITE_COUNT) + 2;
    localparam int A_W           = (BETA_W + 1) + (E_W + 1);
    localparam int PER_ROW       = -LATTICE_SIDE + (((LATTICE_SIDE % 2) == 1) ? 2 : 0);
    localparam int ENERGY_RESET  = 2 * LATTICE_SIDE * PER_ROW;

    localparam int P_W           = 32;
    localparam int CUTOFF_W      = 21;
    localparam int REM_W         = CUTOFF_W + 16;
    localparam int N_W           = 6;
    localparam int ACC_W         = 35;
    localparam int K_W           = 4;
    localparam longint EXP_CUTOFF = 23 * 65536;
    localparam longint LN2_Q32    = 64'd2977044472;
    localparam int EXP_TERMS     = 12;

    localparam logic [BETA_W-1:0] BETA_RESET [BETA_REGS] =
        '{20'd655360, 20'd495235, 20'd285767, 20'd167611, 20'd106160};

    typedef enum logic {
        REQ_FLIP     = 1'b0,
        REQ_EXCHANGE = 1'b1
    } t_req;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_READ, S_FLIPA, S_XMUL,
        S_EVAL, S_EXP, S_COMMIT, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        E_IDLE, E_RED, E_MUL, E_DIV, E_FIN
    } t_exp_state;

endpackage

// ===== rtl/ising_parallel_tempering_step_unit.sv =====
// Top level: five Ising replicas in one spin RAM, Metropolis flips and replica exchange.
// A flip reads five spins, the centre and its four neighbours; with a non-negative exponent
// the result goes straight to commit, otherwise the exp unit is run first.
// An exchange skips the spin reads and runs the exp unit only where it is needed.
// Throughput: one item at a time, so the next transfer follows the result into the output register.
// Reset: synchronous, active low; a clearing pass over all REPLICA_COUNT*SITE_COUNT (81920)
// entries then writes the checkerboard into the spin RAM while input is stalled.
module ising_parallel_tempering_step_unit import ipts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [SITE_W-1:0]    i_site,
    input  logic [UNI_W-1:0]     i_uniform,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_accepted,
    output logic [REP_OUT_W-1:0] o_replica,
    output logic [E_OUT_W-1:0]   o_energy,
    input  logic                 i_cfg_we,
    input  logic [BIDX_W-1:0]    i_cfg_index,
    input  logic [BETA_W-1:0]    i_cfg_data
);

    t_state                 r_state, n_state;
    logic [BETA_W-1:0]      r_beta [BETA_REGS];
    logic signed [E_W-1:0]  r_energy [REPLICA_COUNT];
    logic [IDX_W-1:0]       r_map [REPLICA_COUNT];

    logic [IDX_W-1:0]       r_clr_rep;
    logic [ROW_W-1:0]       r_clr_row, r_clr_col;

    t_req                   r_type;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_site_ok;
    logic [ROW_W-1:0]       r_row, r_col;
    logic [UNI_W-1:0]       r_uniform;
    logic [IDX_W-1:0]       r_rep, r_lo;
    logic [2:0]             r_cnt;
    logic                   r_spin;
    logic [2:0]             r_ones;
    logic signed [4:0]      r_de;
    logic signed [BETA_W:0] r_bdiff;
    logic signed [E_W:0]    r_ediff;
    logic signed [A_W-1:0]  r_a;
    logic                   r_acc;
    logic                   r_res_acc;
    logic [IDX_W-1:0]       r_res_rep;
    logic signed [E_W-1:0]  r_res_energy;

    logic                   r_out_valid;
    logic                   r_out_acc;
    logic [REP_OUT_W-1:0]   r_out_rep;
    logic [E_OUT_W-1:0]     r_out_energy;

    logic                   w_in_xfer, w_out_load;
    logic [IDX_W-1:0]       w_sidx;
    logic [BIDX_W-1:0]      w_bidx;
    logic [ROW_W-1:0]       w_up, w_dn, w_lf, w_rt;
    logic [ADDR_W-1:0]      w_raddr, w_waddr, w_center;
    logic                   w_we, w_wdata, w_rdata;
    logic                   w_exp_start, w_exp_done;
    logic [P_W-1:0]         w_p;
    logic signed [4:0]      w_de;
    logic signed [A_W-1:0]  w_ext_a, w_ext_b, w_neg_a;
    logic signed [E_W-1:0]  w_new_e;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [IDX_W-1:0] rep,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] col);
        f_addr = ADDR_W'(rep) * ADDR_W'(SITE_COUNT) + ADDR_W'(row) * ADDR_W'(LATTICE_SIDE)
               + ADDR_W'(col);
    endfunction

    assign w_in_xfer = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign w_sidx    = IDX_W'(r_slot);
    assign w_bidx    = BIDX_W'(r_slot);

    assign w_up = (r_row == '0) ? ROW_W'(LATTICE_SIDE - 1) : r_row - ROW_W'(1);
    assign w_dn = (r_row == ROW_W'(LATTICE_SIDE - 1)) ? '0 : r_row + ROW_W'(1);
    assign w_lf = (r_col == '0) ? ROW_W'(LATTICE_SIDE - 1) : r_col - ROW_W'(1);
    assign w_rt = (r_col == ROW_W'(LATTICE_SIDE - 1)) ? '0 : r_col + ROW_W'(1);
    assign w_center = f_addr(r_rep, r_row, r_col);

    always_comb begin
        case (r_cnt)
            3'd1:    w_raddr = f_addr(r_rep, w_up, r_col);
            3'd2:    w_raddr = f_addr(r_rep, w_dn, r_col);
            3'd3:    w_raddr = f_addr(r_rep, r_row, w_lf);
            3'd4:    w_raddr = f_addr(r_rep, r_row, w_rt);
            default: w_raddr = w_center;
        endcase
    end

    assign w_we    = (r_state == S_CLEAR) ||
                     (r_state == S_COMMIT && r_type == REQ_FLIP && r_acc);
    assign w_waddr = (r_state == S_CLEAR) ? f_addr(r_clr_rep, r_clr_row, r_clr_col) : w_center;
    assign w_wdata = (r_state == S_CLEAR) ? ~(r_clr_row[0] ^ r_clr_col[0]) : ~r_spin;

    ipts_ram #(
        .WIDTH (1),
        .DEPTH (MEM_DEPTH)
    ) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // dE = -2*s*(2*ones-4) folded into one small expression.
    assign w_de    = r_spin ? (5'sd8 - $signed({2'b00, r_ones} << 2))
                            : ($signed({2'b00, r_ones} << 2) - 5'sd8);
    assign w_neg_a = -r_a;
    assign w_new_e = r_energy[r_rep] + E_W'(r_de);
    assign w_exp_start = (r_state == S_EVAL) && r_a[A_W-1];

    ipts_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_exp_start),
        .i_y     (w_neg_a),
        .o_done  (w_exp_done),
        .o_p     (w_p)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_rep == IDX_W'(REPLICA_COUNT - 1) &&
                    r_clr_row == ROW_W'(LATTICE_SIDE - 1) &&
                    r_clr_col == ROW_W'(LATTICE_SIDE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_slot >= SLOT_W'(REPLICA_COUNT)) begin
                    n_state = S_OUT;
                end else if (r_type == REQ_FLIP) begin
                    n_state = r_site_ok ? S_READ : S_OUT;
                end else begin
                    n_state = (r_slot == '0) ? S_OUT : S_XMUL;
                end
            end
            S_READ: begin
                if (r_cnt == 3'd5) begin
                    n_state = S_FLIPA;
                end
            end
            S_FLIPA:  n_state = S_EVAL;
            S_XMUL:   n_state = S_EVAL;
            S_EVAL:   n_state = r_a[A_W-1] ? S_EXP : S_COMMIT;
            S_EXP: begin
                if (w_exp_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_rep   <= '0;
            r_clr_row   <= '0;
            r_clr_col   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BETA_REGS; i++) begin
                r_beta[i] <= BETA_RESET[i];
            end
            for (int i = 0; i < REPLICA_COUNT; i++) begin
                r_energy[i] <= E_W'(ENERGY_RESET);
                r_map[i]    <= IDX_W'(i);
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we && i_cfg_index < BIDX_W'(BETA_REGS)) begin
                r_beta[i_cfg_index] <= i_cfg_data;
            end

            if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid  <= 1'b1;
                r_out_acc    <= r_res_acc;
                r_out_rep    <= REP_OUT_W'(r_res_rep);
                r_out_energy <= E_OUT_W'(r_res_energy);
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_col <= r_clr_col + ROW_W'(1);
                    if (r_clr_col == ROW_W'(LATTICE_SIDE - 1)) begin
                        r_clr_col <= '0;
                        r_clr_row <= r_clr_row + ROW_W'(1);
                        if (r_clr_row == ROW_W'(LATTICE_SIDE - 1)) begin
                            r_clr_row <= '0;
                            r_clr_rep <= r_clr_rep + IDX_W'(1);
                        end
                    end
                end
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_type    <= t_req'(i_req_type);
                        r_slot    <= i_slot;
                        r_site_ok <= (32'(i_site) < 32'(SITE_COUNT));
                        r_row     <= ROW_W'(i_site / LATTICE_SIDE);
                        r_col     <= ROW_W'(i_site % LATTICE_SIDE);
                        r_uniform <= i_uniform;
                    end
                end
                S_DECODE: begin
                    r_cnt  <= '0;
                    r_ones <= '0;
                    if (r_slot >= SLOT_W'(REPLICA_COUNT)) begin
                        r_res_acc    <= 1'b0;
                        r_res_rep    <= '0;
                        r_res_energy <= '0;
                    end else begin
                        r_rep        <= r_map[w_sidx];
                        r_lo         <= r_map[w_sidx - IDX_W'(1)];
                        r_res_acc    <= 1'b0;
                        r_res_rep    <= r_map[w_sidx];
                        r_res_energy <= r_energy[r_map[w_sidx]];
                        r_bdiff <= $signed({1'b0, r_beta[w_bidx - BIDX_W'(1)]})
                                 - $signed({1'b0, r_beta[w_bidx]});
                        r_ediff <= (E_W+1)'(r_energy[r_map[w_sidx - IDX_W'(1)]])
                                 - (E_W+1)'(r_energy[r_map[w_sidx]]);
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd1) begin
                        r_spin <= w_rdata;
                    end else if (r_cnt != 3'd0) begin
                        r_ones <= r_ones + 3'(w_rdata);
                    end
                end
                S_FLIPA: begin
                    r_de <= w_de;
                    r_a  <= -(A_W'(w_de) * $signed(A_W'({1'b0, r_beta[w_bidx]})));
                end
                S_XMUL: begin
                    r_a <= A_W'(r_bdiff) * A_W'(r_ediff);
                end
                S_EVAL: begin
                    r_acc <= !r_a[A_W-1];
                end
                S_EXP: begin
                    if (w_exp_done) begin
                        r_acc <= (r_uniform < w_p);
                    end
                end
                S_COMMIT: begin
                    r_res_acc <= r_acc;
                    if (r_type == REQ_FLIP) begin
                        r_res_rep <= r_rep;
                        if (r_acc) begin
                            r_energy[r_rep] <= w_new_e;
                            r_res_energy    <= w_new_e;
                        end else begin
                            r_res_energy    <= r_energy[r_rep];
                        end
                    end else if (r_acc) begin
                        r_map[w_sidx - IDX_W'(1)] <= r_rep;
                        r_map[w_sidx]             <= r_lo;
                        r_res_rep                 <= r_lo;
                        r_res_energy              <= r_energy[r_lo];
                    end else begin
                        r_res_rep    <= r_rep;
                        r_res_energy <= r_energy[r_rep];
                    end
                end
                default: ;
            endcase
        end
    end

    // Keep the ext signals tied to the exchange operands for the product check below.
    assign w_ext_a = A_W'(r_bdiff);
    assign w_ext_b = A_W'(r_ediff);

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_acc;
    assign o_replica  = r_out_rep;
    assign o_energy   = r_out_energy;

    a_no_xfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_stall)
        else $error("input taken during the clearing pass");

    a_exp_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exp_done |-> (r_state == S_EXP))
        else $error("exp unit finished while no request waits for it");

    a_ram_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_COMMIT))
        else $error("spin RAM written outside clear or commit");

    a_replica_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_replica < REP_OUT_W'(REPLICA_COUNT)))
        else $error("result names a replica that does not exist");

    a_exchange_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XMUL) |=> (r_a == $past(w_ext_a) * $past(w_ext_b)))
        else $error("exchange exponent does not match its operands");

endmodule

// ===== rtl/ipts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ipts_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ipts_exp.sv =====
// Multi-cycle fixed point exp(-y) unit: range reduction by ln2, then a twelve-term series.
module ipts_exp import ipts_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_y,
    output logic           o_done,
    output logic [P_W-1:0] o_p
);

    t_exp_state         r_state, n_state;
    logic [REM_W-1:0]   r_rem;
    logic [N_W-1:0]     r_n;
    logic [2:0]         r_j;
    logic [31:0]        r_r;
    logic [31:0]        r_term;
    logic [31:0]        r_x;
    logic [31:0]        r_q;
    logic [K_W-1:0]     r_dr;
    logic [1:0]         r_dcnt;
    logic [K_W-1:0]     r_k;
    logic [ACC_W-1:0]   r_acc;
    logic               r_done;
    logic [P_W-1:0]     r_p;

    logic [REM_W-1:0]   w_cmp;
    logic [63:0]        w_prod;
    logic [31:0]        w_x;
    logic [31:0]        w_q;
    logic [K_W-1:0]     w_dr;
    logic [ACC_W-1:0]   w_acc;
    logic [ACC_W-1:0]   w_v;

    assign w_cmp  = REM_W'(LN2_Q32) << r_j;
    assign w_prod = 64'(r_term) * 64'(r_r);

    // Eight restoring division steps per cycle by the small term index.
    always_comb begin
        logic [K_W:0] rem;
        rem  = '0;
        w_x  = r_x;
        w_q  = r_q;
        w_dr = r_dr;
        for (int i = 0; i < 8; i++) begin
            rem  = {w_dr, w_x[31]};
            w_x  = {w_x[30:0], 1'b0};
            if (rem >= {1'b0, r_k}) begin
                rem = rem - {1'b0, r_k};
                w_q = {w_q[30:0], 1'b1};
            end else begin
                w_q = {w_q[30:0], 1'b0};
            end
            w_dr = rem[K_W-1:0];
        end
        w_acc = r_k[0] ? (r_acc - ACC_W'(w_q)) : (r_acc + ACC_W'(w_q));
    end

    assign w_v = r_acc >> r_n;

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_state = (i_y >= A_W'(EXP_CUTOFF)) ? E_IDLE : E_RED;
                end
            end
            E_RED: begin
                if (r_j == 3'd0) begin
                    n_state = E_MUL;
                end
            end
            E_MUL:   n_state = E_DIV;
            E_DIV: begin
                if (r_dcnt == 2'd3) begin
                    n_state = (r_k == K_W'(EXP_TERMS)) ? E_FIN : E_MUL;
                end
            end
            E_FIN:   n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        if (i_y >= A_W'(EXP_CUTOFF)) begin
                            r_p    <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_rem <= REM_W'(i_y[CUTOFF_W-1:0]) << 16;
                            r_n   <= '0;
                            r_j   <= 3'd5;
                        end
                    end
                end
                E_RED: begin
                    if (r_rem >= w_cmp) begin
                        r_rem <= r_rem - w_cmp;
                        r_n   <= r_n | (N_W'(1) << r_j);
                    end
                    r_j <= r_j - 3'd1;
                    if (r_j == 3'd0) begin
                        // The first term is the remainder itself.
                        if (r_rem >= w_cmp) begin
                            r_r    <= 32'(r_rem - w_cmp);
                            r_term <= 32'(r_rem - w_cmp);
                            r_acc  <= (ACC_W'(1) << 32) - ACC_W'(32'(r_rem - w_cmp));
                        end else begin
                            r_r    <= 32'(r_rem);
                            r_term <= 32'(r_rem);
                            r_acc  <= (ACC_W'(1) << 32) - ACC_W'(32'(r_rem));
                        end
                        r_k <= K_W'(2);
                    end
                end
                E_MUL: begin
                    r_x    <= w_prod[63:32];
                    r_q    <= '0;
                    r_dr   <= '0;
                    r_dcnt <= '0;
                end
                E_DIV: begin
                    r_x    <= w_x;
                    r_q    <= w_q;
                    r_dr   <= w_dr;
                    r_dcnt <= r_dcnt + 2'd1;
                    if (r_dcnt == 2'd3) begin
                        r_acc  <= w_acc;
                        r_term <= w_q;
                        r_k    <= r_k + K_W'(1);
                    end
                end
                E_FIN: begin
                    r_p    <= (w_v[ACC_W-1:P_W] != '0) ? '1 : w_v[P_W-1:0];
                    r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the parallel tempering step unit.
`timescale 1ns / 1ps

module testbench;
    import ipts_pkg::*;

    localparam int  CYCLE_LIMIT      = 3000000;
    localparam int  DRAIN_CYCLES     = 200;
    localparam int  IDX_UNUSED       = 7;
    localparam int  BETA_TOP         = 1048575;
    localparam int  PHASE_ITEMS      = 180;
    localparam longint unsigned LN2  = 64'd2977044472;
    localparam longint unsigned CUT  = 64'd23 * 64'd65536;

    typedef struct packed {
        logic               accepted;
        logic [2:0]         replica;
        logic [E_OUT_W-1:0] energy;
    } t_outcome;

    class tempering_scoreboard;
        bit        spin [REPLICA_COUNT][SITE_COUNT];
        int        energy [REPLICA_COUNT];
        int        slot_to_rep [REPLICA_COUNT];
        int        beta [BETA_REGS];
        t_outcome  pending_outcomes [$];
        int        errors;
        int        flips_taken, swaps_taken, outcomes_seen;

        function new();
            for (int k = 0; k < REPLICA_COUNT; k++) begin
                for (int r = 0; r < LATTICE_SIDE; r++)
                    for (int c = 0; c < LATTICE_SIDE; c++)
                        spin[k][r * LATTICE_SIDE + c] = ((r + c) % 2) == 0;
                energy[k] = ENERGY_RESET;
                slot_to_rep[k] = k;
            end
            for (int k = 0; k < BETA_REGS; k++)
                beta[k] = int'(BETA_RESET[k]);
        endfunction

        function void set_beta(int idx, int value);
            if (idx < BETA_REGS)
                beta[idx] = value & BETA_TOP;
        endfunction

        // exp(-y) for y in Q.16, result in Q0.32, by range reduction and a Taylor series.
        function longint unsigned boltzmann_q32(longint unsigned y);
            longint unsigned big, n, r, term, pos, neg, v;
            if (y >= CUT)
                return 0;
            big = y << 16;
            n = big / LN2;
            r = big - n * LN2;
            term = 64'd1 << 32;
            pos = term;
            neg = 0;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * r) >> 32) / k;
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
            end
            v = (pos - neg) >> n;
            if (v > 64'hFFFF_FFFF)
                v = 64'hFFFF_FFFF;
            return v;
        endfunction

        function bit passes(longint a, logic [31:0] uniform);
            if (a >= 0)
                return 1;
            return {32'd0, uniform} < boltzmann_q32(-a);
        endfunction

        function int spin_of(int rep, int idx);
            return spin[rep][idx] ? 1 : -1;
        endfunction

        function void push(bit acc, int rep, int e);
            t_outcome o;
            o.accepted = acc;
            o.replica  = 3'(rep);
            o.energy   = E_OUT_W'(e);
            pending_outcomes.push_back(o);
        endfunction

        function void note_request(t_req req, int slot, int site, logic [31:0] uniform);
            int rep, lo, r, c, up, dn, lf, rt, s, sum, de;
            longint a;
            if (slot >= REPLICA_COUNT) begin
                push(0, 0, 0);
                return;
            end
            rep = slot_to_rep[slot];
            if (req == REQ_FLIP) begin
                if (site >= SITE_COUNT) begin
                    push(0, rep, energy[rep]);
                    return;
                end
                r = site / LATTICE_SIDE;
                c = site % LATTICE_SIDE;
                up = (r == 0) ? LATTICE_SIDE - 1 : r - 1;
                dn = (r == LATTICE_SIDE - 1) ? 0 : r + 1;
                lf = (c == 0) ? LATTICE_SIDE - 1 : c - 1;
                rt = (c == LATTICE_SIDE - 1) ? 0 : c + 1;
                s = spin_of(rep, site);
                sum = spin_of(rep, up * LATTICE_SIDE + c) + spin_of(rep, dn * LATTICE_SIDE + c)
                    + spin_of(rep, r * LATTICE_SIDE + lf) + spin_of(rep, r * LATTICE_SIDE + rt);
                de = -2 * s * sum;
                a = -longint'(de) * longint'(beta[slot]);
                if (passes(a, uniform)) begin
                    spin[rep][site] = !spin[rep][site];
                    energy[rep] += de;
                    flips_taken++;
                    push(1, rep, energy[rep]);
                end else begin
                    push(0, rep, energy[rep]);
                end
            end else begin
                if (slot == 0) begin
                    push(0, rep, energy[rep]);
                    return;
                end
                lo = slot_to_rep[slot - 1];
                a = (longint'(beta[slot - 1]) - longint'(beta[slot]))
                    * (longint'(energy[lo]) - longint'(energy[rep]));
                if (passes(a, uniform)) begin
                    slot_to_rep[slot - 1] = rep;
                    slot_to_rep[slot] = lo;
                    swaps_taken++;
                    push(1, lo, energy[lo]);
                end else begin
                    push(0, rep, energy[rep]);
                end
            end
        endfunction

        function void check_outcome(logic acc, logic [2:0] rep, logic [E_OUT_W-1:0] e);
            t_outcome want;
            outcomes_seen++;
            if (pending_outcomes.size() == 0) begin
                $error("result with no request outstanding: accepted %0d replica %0d energy %0h",
                       acc, rep, e);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (acc !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, acc);
                errors++;
            end
            if (rep !== want.replica) begin
                $error("replica: expected %0d, actual %0d", want.replica, rep);
                errors++;
            end
            if (e !== want.energy) begin
                $error("energy: expected %0h, actual %0h", want.energy, e);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_req_type  = 1'b0;
    logic [SLOT_W-1:0]    i_slot      = '0;
    logic [SITE_W-1:0]    i_site      = '0;
    logic [UNI_W-1:0]     i_uniform   = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic                 o_accepted;
    logic [REP_OUT_W-1:0] o_replica;
    logic [E_OUT_W-1:0]   o_energy;
    logic                 i_cfg_we    = 1'b0;
    logic [BIDX_W-1:0]    i_cfg_index = '0;
    logic [BETA_W-1:0]    i_cfg_data  = '0;

    tempering_scoreboard sb;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;
    int requests_sent = 0;

    ising_parallel_tempering_step_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // A long hold-off takes priority over the random stall pattern.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = $urandom_range(99) < receiver_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_outcome(o_accepted, o_replica, o_energy);
    end

    task automatic write_beta(int idx, int value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = BIDX_W'(idx);
        i_cfg_data = BETA_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_beta(idx, value);
    endtask

    // Valid stays high from one transfer into the next unless an idle gap is drawn.
    task automatic send_request(t_req req, int slot, int site, logic [31:0] uniform);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type = req;
        i_slot = SLOT_W'(slot);
        i_site = SITE_W'(site);
        i_uniform = uniform;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req, slot, site, uniform);
        requests_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_request();
        int pick, row, site, slot;
        logic [31:0] u;
        t_req req;
        pick = $urandom_range(99);
        u = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom;
        // Flips mostly land in a narrow band that wraps top to bottom so the lattice evolves.
        row = ($urandom_range(4) == 4) ? LATTICE_SIDE - 1 : $urandom_range(3);
        site = row * LATTICE_SIDE + $urandom_range(LATTICE_SIDE - 1);
        if ($urandom_range(9) == 0)
            site = $urandom_range(SITE_COUNT - 1);
        if (pick < 72) begin
            req = REQ_FLIP;
            slot = $urandom_range(REPLICA_COUNT - 1);
        end else if (pick < 94) begin
            req = REQ_EXCHANGE;
            slot = ($urandom_range(19) == 0) ? 0 : $urandom_range(REPLICA_COUNT - 1, 1);
        end else begin
            req = t_req'($urandom_range(1));
            slot = $urandom_range(7, REPLICA_COUNT);
        end
        send_request(req, slot, site, u);
    endtask

    initial begin
        int betas [4][BETA_REGS];
        sb = new();
        betas[0] = '{0, 0, 0, 0, 0};
        betas[1] = '{BETA_TOP, 0, BETA_TOP, 0, BETA_TOP};
        betas[2] = '{20000, 15000, 11000, 7000, 3000};
        betas[3] = '{int'(BETA_RESET[0]), int'(BETA_RESET[1]), int'(BETA_RESET[2]),
                     int'(BETA_RESET[3]), int'(BETA_RESET[4])};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: corners with wraparound, both uniform extremes, every slot case.
        write_beta(IDX_UNUSED, BETA_TOP);
        send_request(REQ_FLIP, 0, 0, 32'd0);
        send_request(REQ_FLIP, 4, LATTICE_SIDE - 1, 32'd0);
        send_request(REQ_FLIP, 4, SITE_COUNT - LATTICE_SIDE, 32'hFFFF_FFFF);
        send_request(REQ_FLIP, 3, SITE_COUNT - 1, 32'd0);
        send_request(REQ_FLIP, 3, 1, 32'd0);
        send_request(REQ_FLIP, 3, 0, 32'hFFFF_FFFF);
        send_request(REQ_FLIP, 4, 0, 32'd0);
        send_request(REQ_EXCHANGE, 0, 0, 32'd0);
        for (int k = 1; k < REPLICA_COUNT; k++)
            send_request(REQ_EXCHANGE, k, 0, 32'd0);
        send_request(REQ_EXCHANGE, 4, 0, 32'hFFFF_FFFF);
        send_request(REQ_FLIP, 5, 0, 32'd0);
        send_request(REQ_EXCHANGE, 6, SITE_COUNT - 1, 32'd0);
        send_request(REQ_FLIP, 7, 100, 32'hFFFF_FFFF);
        send_request(REQ_FLIP, 1, 12345, 32'h5555_5555);
        send_request(REQ_FLIP, 2, 2730, 32'hAAAA_AAAA);
        wait_quiet();

        // Random part: each beta setting is run under two of the four idling patterns.
        for (int b = 0; b < 2; b++) begin
            for (int m = 0; m < 4; m++) begin
                for (int k = 0; k < BETA_REGS; k++)
                    write_beta(k, betas[(b * 2 + m) % 4][k]);
                sender_idle_pct    = (m == 1 || m == 3) ? ((m == 3) ? 34 : 68) : 0;
                receiver_stall_pct = (m == 2 || m == 3) ? ((m == 3) ? 34 : 68) : 0;
                for (int n = 0; n < PHASE_ITEMS; n++) begin
                    if (b == 0 && m == 0 && n == 40)
                        hold_left = 600;
                    random_request();
                end
                wait_quiet();
            end
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_quiet();

        $display("%0d requests, %0d results checked, %0d flips and %0d swaps accepted",
                 requests_sent, sb.outcomes_seen, sb.flips_taken, sb.swaps_taken);
        $display("four beta settings including all-zero and full-scale, four idling patterns");
        if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
